// ===== rtl/core/vt4_pkg.sv =====
// vt4_pkg: shared types, constants and reset values for the 4x4 vertex transform.
// No dependencies.
package vt4_pkg;

  localparam int unsigned FIELD_W           = 32;
  localparam int unsigned REG_W             = 64;
  localparam int unsigned HALF_W            = 32;
  localparam int unsigned NUM_REGS          = 8;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned DIM               = 4;
  localparam int unsigned DEF_FRAC_BITS     = 16;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  // register index map: column C, rows 0/1 at 2C, rows 2/3 at 2C+1
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL0_ROWS01 = 3'd0,
    REG_COL0_ROWS23 = 3'd1,
    REG_COL1_ROWS01 = 3'd2,
    REG_COL1_ROWS23 = 3'd3,
    REG_COL2_ROWS01 = 3'd4,
    REG_COL2_ROWS23 = 3'd5,
    REG_COL3_ROWS01 = 3'd6,
    REG_COL3_ROWS23 = 3'd7
  } vt4_reg_t;

  // per-stage load enables of the reduction stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } vt4_pipe_en_t;

  // identity matrix in fixed point with fb fraction bits
  function automatic logic [REG_W-1:0] cfg_reset_val(vt4_reg_t idx, int unsigned fb);
    logic [REG_W-1:0] one;
    one = REG_W'(1) << fb;
    case (idx)
      REG_COL0_ROWS01: cfg_reset_val = one;
      REG_COL1_ROWS01: cfg_reset_val = one << HALF_W;
      REG_COL2_ROWS23: cfg_reset_val = one;
      REG_COL3_ROWS23: cfg_reset_val = one << HALF_W;
      default:         cfg_reset_val = '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/vt4_matrix_regs.sv =====
// vt4_matrix_regs: configuration register file holding the 4x4 matrix.
// Depends on vt4_pkg.
module vt4_matrix_regs #(
  parameter int unsigned FRAC_BITS     = vt4_pkg::DEF_FRAC_BITS,
  parameter int unsigned ELEMENT_WIDTH = vt4_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]           cfg_data,
  // m[col][row]
  output logic signed [ELEMENT_WIDTH-1:0]     m [vt4_pkg::DIM][vt4_pkg::DIM]
);
  import vt4_pkg::*;

  logic [REG_W-1:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= cfg_reset_val(vt4_reg_t'(i), FRAC_BITS);
      end
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        m[c][r] = regs_r[c*2 + r/2][(r%2)*HALF_W +: ELEMENT_WIDTH];
      end
    end
  end

endmodule

// ===== rtl/core/vt4_mult_array.sv =====
// vt4_mult_array: first pipeline stage, sixteen registered element products.
// Depends on vt4_pkg.
module vt4_mult_array #(
  parameter int unsigned ELEMENT_WIDTH = vt4_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ELEMENT_WIDTH-1:0]   v    [vt4_pkg::DIM],
  input  logic signed [ELEMENT_WIDTH-1:0]   m    [vt4_pkg::DIM][vt4_pkg::DIM],
  // prod[row][col]
  output logic signed [2*ELEMENT_WIDTH-1:0] prod [vt4_pkg::DIM][vt4_pkg::DIM]
);
  import vt4_pkg::*;

  localparam int unsigned PW = 2 * ELEMENT_WIDTH;

  logic signed [PW-1:0] prod_r [DIM][DIM];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_r[r][c] <= PW'(m[c][r]) * PW'(v[c]);
        end
      end
    end
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/vt4_row_reduce.sv =====
// vt4_row_reduce: one output row, two adder stages then floor shift and saturate.
// Depends on vt4_pkg.
module vt4_row_reduce #(
  parameter int unsigned FRAC_BITS     = vt4_pkg::DEF_FRAC_BITS,
  parameter int unsigned ELEMENT_WIDTH = vt4_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  vt4_pkg::vt4_pipe_en_t             en,
  input  logic signed [2*ELEMENT_WIDTH-1:0] prod [vt4_pkg::DIM],
  output logic signed [ELEMENT_WIDTH-1:0]   res,
  output logic                              sat
);
  import vt4_pkg::*;

  localparam int unsigned PW = 2 * ELEMENT_WIDTH;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned HW = SW - ELEMENT_WIDTH + 1;

  logic signed [AW-1:0]            s01_r, s23_r;
  logic signed [SW-1:0]            sum_r;
  logic signed [SW-1:0]            shifted;
  logic signed [ELEMENT_WIDTH-1:0] res_r, res_nxt;
  logic                            sat_r, sat_nxt;
  logic [HW-1:0]                   top_bits;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s01_r <= AW'(prod[0]) + AW'(prod[1]);
      s23_r <= AW'(prod[2]) + AW'(prod[3]);
    end
    if (en.s3) begin
      sum_r <= SW'(s01_r) + SW'(s23_r);
    end
    if (en.s4) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  // arithmetic shift gives floor; value fits when all bits above the
  // element's sign bit match it
  always_comb begin
    shifted  = sum_r >>> FRAC_BITS;
    top_bits = shifted[SW-1:ELEMENT_WIDTH-1];
    if (top_bits == '0 || top_bits == '1) begin
      res_nxt = shifted[ELEMENT_WIDTH-1:0];
      sat_nxt = 1'b0;
    end else begin
      res_nxt = shifted[SW-1] ? {1'b1, {(ELEMENT_WIDTH-1){1'b0}}}
                              : {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
      sat_nxt = 1'b1;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ===== rtl/core/vertex_transform_4x4_core.sv =====
// vertex_transform_4x4_core: top level, 4x4 fixed-point matrix times vertex.
// Depends on vt4_pkg, vt4_matrix_regs, vt4_mult_array, vt4_row_reduce.
//
// Usage:
//   Input channel in_valid/in_stall carries one vertex word (in_x..in_w,
//   signed fixed point). Output channel out_valid/out_stall carries the
//   transformed word (out_x..out_w) and out_saturated, set when any
//   component was clamped. A word moves when valid is high and stall low.
//   The matrix is written through cfg_we/cfg_index/cfg_data, column-major,
//   two elements per register; write it only while no word is in flight.
// Pipeline: four register stages (multiply, two adder stages, shift/saturate);
//   out_valid is the valid bit of the last stage. Throughput: one vertex per
//   cycle while out_stall is low; the sixteen multipliers run in parallel so
//   every stage takes a new word each cycle unless a stall holds it.
// Reset (rst_n low, synchronous): pipeline emptied, matrix set to identity.
// Receiver stall: the pipeline holds its words; empty stages still fill, so
//   up to four words are accepted before in_stall rises. Nothing is lost or
//   repeated.
module vertex_transform_4x4_core #(
  parameter int unsigned FRAC_BITS     = vt4_pkg::DEF_FRAC_BITS,
  parameter int unsigned ELEMENT_WIDTH = vt4_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_x,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_y,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_z,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vt4_pkg::FIELD_W-1:0]   out_x,
  output logic [vt4_pkg::FIELD_W-1:0]   out_y,
  output logic [vt4_pkg::FIELD_W-1:0]   out_z,
  output logic [vt4_pkg::FIELD_W-1:0]   out_w,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [vt4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]     cfg_data
);
  import vt4_pkg::*;

  localparam int unsigned PW = 2 * ELEMENT_WIDTH;

  logic signed [ELEMENT_WIDTH-1:0] m    [DIM][DIM];
  logic signed [ELEMENT_WIDTH-1:0] v    [DIM];
  logic signed [PW-1:0]            prod [DIM][DIM];
  logic signed [ELEMENT_WIDTH-1:0] res  [DIM];
  logic [DIM-1:0]                  sat;

  logic         v1_r, v2_r, v3_r, v4_r;
  logic         en1;
  vt4_pipe_en_t en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en.s4 = !v4_r || !out_stall;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en1   = !v1_r || en.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1)  v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  assign in_stall = !en1;

  assign v[0] = in_x[ELEMENT_WIDTH-1:0];
  assign v[1] = in_y[ELEMENT_WIDTH-1:0];
  assign v[2] = in_z[ELEMENT_WIDTH-1:0];
  assign v[3] = in_w[ELEMENT_WIDTH-1:0];

  vt4_matrix_regs #(
    .FRAC_BITS     (FRAC_BITS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m         (m)
  );

  vt4_mult_array #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mult (
    .clk  (clk),
    .en   (en1),
    .v    (v),
    .m    (m),
    .prod (prod)
  );

  for (genvar r = 0; r < DIM; r++) begin : g_row
    vt4_row_reduce #(
      .FRAC_BITS     (FRAC_BITS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_row (
      .clk  (clk),
      .en   (en),
      .prod (prod[r]),
      .res  (res[r]),
      .sat  (sat[r])
    );
  end

  assign out_valid     = v4_r;
  assign out_x         = FIELD_W'(res[0]);
  assign out_y         = FIELD_W'(res[1]);
  assign out_z         = FIELD_W'(res[2]);
  assign out_w         = FIELD_W'(res[3]);
  assign out_saturated = |sat;

endmodule

// ===== bench/vt4_transform_checker.sv =====
// vt4_transform_checker: watches the vertex and result channels of the 4x4 transform,
// keeps its own copy of the matrix and predicts every transformed word in order.
// Depends on vt4_pkg for widths and register names.
`timescale 1ns / 1ps

module vt4_transform_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_x,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_y,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_z,
  input  logic [vt4_pkg::FIELD_W-1:0]   in_w,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [vt4_pkg::FIELD_W-1:0]   out_x,
  input  logic [vt4_pkg::FIELD_W-1:0]   out_y,
  input  logic [vt4_pkg::FIELD_W-1:0]   out_z,
  input  logic [vt4_pkg::FIELD_W-1:0]   out_w,
  input  logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [vt4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            clamped
);
  import vt4_pkg::*;

  localparam int unsigned FRAC = DEF_FRAC_BITS;
  localparam logic signed [65:0] COMP_MAX = (66'sd1 <<< 31) - 66'sd1;
  localparam logic signed [65:0] COMP_MIN = -(66'sd1 <<< 31);
  localparam logic [REG_W-1:0]   FX_ONE64 = REG_W'(1) << FRAC;

  typedef struct packed {
    logic [DIM-1:0][FIELD_W-1:0] comp;
    logic                        sat;
  } vt4_word_t;

  logic [REG_W-1:0] matrix_mirror [NUM_REGS];
  vt4_word_t        xformed_q [$];
  vt4_word_t        want;
  vt4_word_t        got;
  int               errs = 0;
  int               n_checked = 0;
  int               n_clamped = 0;
  string            comp_name [DIM] = '{"out_x", "out_y", "out_z", "out_w"};

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    clamped    = 0;
  end

  // column-major: row r of the result sums element (c, r) times component c
  function automatic vt4_word_t transform_vertex(input logic [FIELD_W-1:0] vx, vy, vz, vw);
    logic signed [31:0] vin [DIM];
    logic signed [31:0] elem;
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    vt4_word_t          res;
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
    vin[3] = vw;
    res = '0;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++) begin
        elem = matrix_mirror[c * 2 + r / 2][(r % 2) * HALF_W +: HALF_W];
        prod = elem * vin[c];
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC;  // floor
      if (scaled > COMP_MAX) begin
        res.comp[r] = COMP_MAX[31:0];
        res.sat     = 1'b1;
      end else if (scaled < COMP_MIN) begin
        res.comp[r] = COMP_MIN[31:0];
        res.sat     = 1'b1;
      end else begin
        res.comp[r] = scaled[31:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      xformed_q.delete();
      for (int i = 0; i < NUM_REGS; i++) matrix_mirror[i] = '0;
      matrix_mirror[REG_COL0_ROWS01] = FX_ONE64;
      matrix_mirror[REG_COL1_ROWS01] = FX_ONE64 << HALF_W;
      matrix_mirror[REG_COL2_ROWS23] = FX_ONE64;
      matrix_mirror[REG_COL3_ROWS23] = FX_ONE64 << HALF_W;
    end else begin
      if (out_valid && !out_stall) begin
        got.comp = {out_w, out_z, out_y, out_x};
        got.sat  = out_saturated;
        if (xformed_q.size() == 0) begin
          errs++;
          $display("%0t: result word with none expected: got %h sat %b", $time, got.comp,
                   got.sat);
        end else begin
          want = xformed_q.pop_front();
          n_checked++;
          if (want.sat) n_clamped++;
          for (int i = 0; i < DIM; i++) begin
            if (got.comp[i] !== want.comp[i]) begin
              errs++;
              $display("%0t: %s mismatch: expected %h, got %h", $time, comp_name[i],
                       want.comp[i], got.comp[i]);
            end
          end
          if (got.sat !== want.sat) begin
            errs++;
            $display("%0t: out_saturated mismatch: expected %b, got %b", $time, want.sat,
                     got.sat);
          end
        end
      end
      if (in_valid && !in_stall) xformed_q.push_back(transform_vertex(in_x, in_y, in_z, in_w));
      if (cfg_we) matrix_mirror[cfg_index] = cfg_data;
    end
    fail_count <= errs;
    pending    <= xformed_q.size();
    checked    <= n_checked;
    clamped    <= n_clamped;
  end

endmodule

// ===== bench/tb_vertex_transform_4x4_core.sv =====
// tb_vertex_transform_4x4_core: stimulus and verdict for the 4x4 vertex transform.
// Loads a series of matrices, streams vertices under random idling on both sides;
// depends on vt4_pkg, vt4_transform_checker and the core.
`timescale 1ns / 1ps

module tb_vertex_transform_4x4_core;
  import vt4_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int BLOCKS      = 7;
  localparam int BLOCK_WORDS = 100;

  localparam logic [31:0] FX_ZERO    = 32'h0000_0000;
  localparam logic [31:0] FX_LSB     = 32'h0000_0001;
  localparam logic [31:0] FX_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [31:0] FX_ONE     = 32'h0001_0000;
  localparam logic [31:0] FX_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] FX_NEG_HALF = 32'hFFFF_8000;
  localparam logic [31:0] FX_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN     = 32'h8000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FIELD_W-1:0]   in_x = '0;
  logic [FIELD_W-1:0]   in_y = '0;
  logic [FIELD_W-1:0]   in_z = '0;
  logic [FIELD_W-1:0]   in_w = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   out_x;
  logic [FIELD_W-1:0]   out_y;
  logic [FIELD_W-1:0]   out_z;
  logic [FIELD_W-1:0]   out_w;
  logic                 out_saturated;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int clamped;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int vertices_sent = 0;
  int matrix_loads = 0;

  // staged matrix, [column][row]
  logic [31:0] mat [DIM][DIM];

  vertex_transform_4x4_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_w         (in_w),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  vt4_transform_checker xform_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_w         (in_w),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .clamped      (clamped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // mix of full-range, corner and small (about +/-16.0) fixed-point values
  function automatic logic [31:0] rand_fixed(input int wide_pct);
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    if (pick < wide_pct) return $urandom();
    if (pick < wide_pct + 10) begin
      case ($urandom_range(6))
        0: v = FX_ZERO;
        1: v = FX_LSB;
        2: v = FX_NEG_LSB;
        3: v = FX_ONE;
        4: v = FX_NEG_ONE;
        5: v = FX_MAX;
        default: v = FX_MIN;
      endcase
      return v;
    end
    v = $urandom_range(32'h000F_FFFF);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic send_vertex(input logic [31:0] vx, vy, vz, vw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_x     <= $urandom();
      in_y     <= $urandom();
      in_z     <= $urandom();
      in_w     <= $urandom();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= vx;
    in_y     <= vy;
    in_z     <= vz;
    in_w     <= vw;
    do @(posedge clk); while (in_stall);
    vertices_sent++;
  endtask

  // hold off the sender until every expected word has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic fill_matrix(input logic [31:0] v);
    for (int c = 0; c < DIM; c++)
      for (int r = 0; r < DIM; r++) mat[c][r] = v;
  endtask

  task automatic write_matrix();
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= vt4_reg_t'(i);
      cfg_data  <= {mat[i / 2][(i % 2) * 2 + 1], mat[i / 2][(i % 2) * 2]};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    matrix_loads++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 34;
    rx_idle_pct = 60;

    // identity straight out of reset
    send_vertex(FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO);
    send_vertex(FX_MAX, FX_MIN, FX_NEG_LSB, FX_LSB);
    send_vertex(FX_MIN, FX_MAX, FX_ONE, FX_NEG_ONE);

    fill_matrix(FX_MAX);
    write_matrix();
    send_vertex(FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_vertex(FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_vertex(FX_LSB, FX_NEG_LSB, FX_ZERO, FX_ZERO);
    send_vertex(FX_LSB, FX_ZERO, FX_ZERO, FX_ZERO);

    fill_matrix(FX_MIN);
    write_matrix();
    send_vertex(FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_vertex(FX_NEG_LSB, FX_ZERO, FX_ZERO, FX_ZERO);
    send_vertex(FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_vertex(FX_LSB, FX_ZERO, FX_ZERO, FX_ZERO);

    // negative fractions: floor rounding
    fill_matrix(FX_NEG_HALF);
    write_matrix();
    send_vertex(FX_LSB, FX_ZERO, FX_ZERO, FX_ZERO);
    send_vertex(FX_LSB, FX_LSB, FX_LSB, FX_ZERO);
    send_vertex(FX_NEG_LSB, FX_ZERO, FX_ZERO, FX_ZERO);

    // one LSB either side of the clamp limits
    fill_matrix(FX_ZERO);
    for (int r = 0; r < DIM; r++) mat[0][r] = FX_ONE;
    mat[1][0] = FX_LSB;
    mat[1][1] = FX_NEG_LSB;
    write_matrix();
    send_vertex(FX_MAX, FX_ONE, FX_ZERO, FX_ZERO);
    send_vertex(FX_MIN, FX_LSB, FX_ZERO, FX_ZERO);
    send_vertex(FX_MAX, FX_ZERO, FX_MAX, FX_MAX);

    fill_matrix(FX_ZERO);
    write_matrix();
    send_vertex(FX_MAX, FX_MIN, FX_MAX, FX_MIN);

    fill_matrix(FX_NEG_LSB);
    write_matrix();
    send_vertex(FX_MIN, FX_MIN, FX_MIN, FX_MIN);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      wait_idle();
      if (blk < 3) begin
        tx_idle_pct = 34;
        rx_idle_pct = 60;
      end else if (blk < 5) begin
        tx_idle_pct = 60;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int c = 0; c < DIM; c++)
        for (int r = 0; r < DIM; r++)
          mat[c][r] = rand_fixed((blk == 1 || blk == 4) ? 100 : (blk == 6 ? 0 : 15));
      write_matrix();
      repeat (BLOCK_WORDS)
        send_vertex(rand_fixed(20), rand_fixed(20), rand_fixed(20), rand_fixed(20));
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d vertices over %0d matrix loads plus the reset identity;",
             vertices_sent, matrix_loads);
    $display("%0d results compared, %0d of them clamped.", checked, clamped);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
